// ===== hdl/lscd_pkg.sv =====
// ----------------------------------------------------------------------------
// lscd_pkg
// Shared sizes, codes and types of the LRU sector cache directory.
// ----------------------------------------------------------------------------
package lscd_pkg;

	// directory size and derived widths
	localparam int ENTRIES    = 16;
	localparam int SLOT_W     = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int SEC_W      = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [SEC_W-1:0]     sec_t;
	typedef logic [OP_W-1:0]      op_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// request operation codes
	localparam op_t OP_READ  = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_FLUSH = 2'd2;

	// configuration register indexes
	localparam cfg_idx_t CFG_WT_MODE   = 1'b0;
	localparam cfg_idx_t CFG_PART_BASE = 1'b1;

	// move one slot to the front of the recency list
	typedef struct packed {
		logic  en;
		slot_t pos;
		slot_t slot;
	} lru_shift_t;

	// tag memory write request
	typedef struct packed {
		logic  en;
		slot_t addr;
		sec_t  data;
	} tag_wr_t;

endpackage

// ===== hdl/lscd_tag_ram.sv =====
// ----------------------------------------------------------------------------
// lscd_tag_ram
// Tag memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lscd_tag_ram import lscd_pkg::*; (
	input  logic    clk,
	input  logic    rd_en,
	input  slot_t   rd_addr,
	output sec_t    rd_data,
	input  tag_wr_t wr
);

	sec_t mem_q [ENTRIES];
	sec_t rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/lscd_recency.sv =====
// ----------------------------------------------------------------------------
// lscd_recency
// Recency list: position 0 holds the most recent slot, the last position the
// least recent one once the directory is full.
// ----------------------------------------------------------------------------
module lscd_recency import lscd_pkg::*; (
	input  logic       clk,
	input  slot_t      rd_pos,
	output slot_t      rd_slot,
	output slot_t      victim_slot,
	input  lru_shift_t shift
);

	slot_t order_q [ENTRIES];

	// shift positions 1..pos down by one and put the slot in front
	always_ff @(posedge clk) begin
		if (shift.en) begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (k == 0) begin
					order_q[k] <= shift.slot;
				end else if (k <= int'(shift.pos)) begin
					order_q[k] <= order_q[k-1];
				end
			end
		end
	end

	assign rd_slot     = order_q[rd_pos];
	assign victim_slot = order_q[ENTRIES-1];

endmodule

// ===== hdl/lscd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lscd_ctrl
// Request sequencer: walks the recency list through the tag memory with one
// shared comparator and one shared adder, updates dirty bits and fill count,
// and holds the result register.
// ----------------------------------------------------------------------------
module lscd_ctrl import lscd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  op_t                   operation,
	input  sec_t                  sector,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot,
	output logic                  fill_from_disk,
	output logic                  write_to_disk,
	output sec_t                  disk_sector,
	output logic                  writeback,
	output sec_t                  writeback_sector,
	output logic                  last,
	// configuration
	input  logic                  wt_mode,
	input  sec_t                  part_base,
	// recency list and tag memory
	output slot_t                 rd_pos,
	input  slot_t                 rd_slot,
	input  slot_t                 victim_slot,
	output lru_shift_t            lru_shift,
	output logic                  tag_rd_en,
	input  sec_t                  tag_rd_data,
	output tag_wr_t               tag_wr
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_RESP    = 6'b000100,
		ST_FL_RD   = 6'b001000,
		ST_FL_WB   = 6'b010000,
		ST_FL_NONE = 6'b100000
	} state_t;

	state_t              state_q;
	cnt_t                iss_k_q;
	cnt_t                used_q;
	cnt_t                rem_q;
	slot_t               fl_k_q;
	logic [ENTRIES-1:0]  dirty_q;
	logic                cmp_vld_s1;
	slot_t               cmp_pos_s1;
	slot_t               cmp_slot_s1;
	slot_t               fl_slot_s1;
	op_t                 op_q;
	sec_t                sec_q;
	sec_t                dsec_q;
	logic                hit_q;
	slot_t               hit_pos_q;
	slot_t               hit_slot_q;

	logic                  out_valid_q;
	logic                  o_hit_q;
	logic [SLOT_OUT_W-1:0] o_slot_q;
	logic                  o_fill_q;
	logic                  o_wtd_q;
	sec_t                  o_dsec_q;
	logic                  o_wb_q;
	sec_t                  o_wbsec_q;
	logic                  o_last_q;

	logic  can_emit;
	logic  in_acc;
	sec_t  add_b;
	sec_t  add_sum;
	logic  full;
	logic  scan_more;
	logic  scan_issue;
	logic  scan_hit;
	logic  scan_miss;
	slot_t r_slot;
	slot_t r_pos;
	logic  r_wb;
	logic  is_wr;
	logic  resp_fire;
	logic  fl_dirty;
	logic  fl_fire;
	logic  none_fire;
	cnt_t  dirty_cnt;

	// handshake helpers
	assign can_emit = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && (state_q == ST_IDLE);

	// shared adder: request sector at accept, stored tag otherwise
	assign add_b   = (state_q == ST_IDLE) ? sector : tag_rd_data;
	assign add_sum = part_base + add_b;

	// scan over recency positions, one tag read per cycle
	assign full       = (used_q == cnt_t'(ENTRIES));
	assign scan_more  = (iss_k_q < used_q);
	assign scan_issue = (state_q == ST_SCAN) && scan_more;
	assign scan_hit   = (state_q == ST_SCAN) && cmp_vld_s1 && (tag_rd_data == sec_q);
	assign scan_miss  = (state_q == ST_SCAN) && !cmp_vld_s1 && !scan_more;

	assign tag_rd_en = scan_issue || (state_q == ST_FL_RD);
	assign rd_pos    = (state_q == ST_FL_RD) ? fl_k_q : iss_k_q[SLOT_W-1:0];
	assign dirty_cnt = cnt_t'($countones(dirty_q));

	// slot and recency position picked for the response
	always_comb begin
		priority if (hit_q) begin
			r_slot = hit_slot_q;
			r_pos  = hit_pos_q;
		end else if (!full) begin
			r_slot = used_q[SLOT_W-1:0];
			r_pos  = used_q[SLOT_W-1:0];
		end else begin
			r_slot = victim_slot;
			r_pos  = slot_t'(ENTRIES - 1);
		end
	end

	assign r_wb      = !hit_q && full && dirty_q[r_slot];
	assign is_wr     = (op_q == OP_WRITE);
	assign resp_fire = (state_q == ST_RESP) && can_emit;
	assign fl_dirty  = dirty_q[fl_slot_s1];
	assign fl_fire   = (state_q == ST_FL_WB) && fl_dirty && can_emit;
	assign none_fire = (state_q == ST_FL_NONE) && can_emit;

	// recency and tag updates on the response transfer
	assign lru_shift.en   = resp_fire;
	assign lru_shift.pos  = r_pos;
	assign lru_shift.slot = r_slot;
	assign tag_wr.en      = resp_fire && !hit_q;
	assign tag_wr.addr    = r_slot;
	assign tag_wr.data    = sec_q;

	// sequencer, fill count and dirty bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_k_q     <= '0;
			used_q      <= '0;
			rem_q       <= '0;
			fl_k_q      <= '0;
			dirty_q     <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= scan_issue;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (operation)
							OP_READ, OP_WRITE: begin
								iss_k_q <= '0;
								state_q <= ST_SCAN;
							end
							OP_FLUSH: begin
								rem_q  <= dirty_cnt;
								fl_k_q <= slot_t'(used_q - cnt_t'(1));
								if (dirty_cnt == '0) begin
									state_q <= ST_FL_NONE;
								end else begin
									state_q <= ST_FL_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						iss_k_q <= iss_k_q + cnt_t'(1);
					end
					if (scan_hit || scan_miss) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (resp_fire) begin
						if (!hit_q && !full) begin
							used_q <= used_q + cnt_t'(1);
						end
						if (hit_q) begin
							if (is_wr) begin
								dirty_q[r_slot] <= !wt_mode;
							end
						end else begin
							dirty_q[r_slot] <= is_wr && !wt_mode;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_FL_RD: begin
					state_q <= ST_FL_WB;
				end
				ST_FL_WB: begin
					if (!fl_dirty) begin
						fl_k_q  <= fl_k_q - slot_t'(1);
						state_q <= ST_FL_RD;
					end else if (can_emit) begin
						rem_q <= rem_q - cnt_t'(1);
						if (rem_q == cnt_t'(1)) begin
							dirty_q <= '0;
							used_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							fl_k_q  <= fl_k_q - slot_t'(1);
							state_q <= ST_FL_RD;
						end
					end
				end
				ST_FL_NONE: begin
					if (can_emit) begin
						used_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// result register valid
			if (resp_fire || fl_fire || none_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= operation;
			sec_q  <= sector;
			dsec_q <= add_sum;
		end
		cmp_pos_s1  <= iss_k_q[SLOT_W-1:0];
		cmp_slot_s1 <= rd_slot;
		if (state_q == ST_FL_RD) begin
			fl_slot_s1 <= rd_slot;
		end
		if (scan_hit) begin
			hit_q      <= 1'b1;
			hit_pos_q  <= cmp_pos_s1;
			hit_slot_q <= cmp_slot_s1;
		end else if (scan_miss) begin
			hit_q <= 1'b0;
		end
		priority if (resp_fire) begin
			o_hit_q   <= hit_q;
			o_slot_q  <= SLOT_OUT_W'(r_slot);
			o_fill_q  <= !hit_q && (op_q == OP_READ);
			o_wtd_q   <= is_wr && wt_mode;
			o_dsec_q  <= dsec_q;
			o_wb_q    <= r_wb;
			o_wbsec_q <= r_wb ? add_sum : '0;
			o_last_q  <= 1'b1;
		end else if (fl_fire) begin
			o_hit_q   <= 1'b0;
			o_slot_q  <= SLOT_OUT_W'(fl_slot_s1);
			o_fill_q  <= 1'b0;
			o_wtd_q   <= 1'b0;
			o_dsec_q  <= '0;
			o_wb_q    <= 1'b1;
			o_wbsec_q <= add_sum;
			o_last_q  <= (rem_q == cnt_t'(1));
		end else if (none_fire) begin
			o_hit_q   <= 1'b0;
			o_slot_q  <= '0;
			o_fill_q  <= 1'b0;
			o_wtd_q   <= 1'b0;
			o_dsec_q  <= '0;
			o_wb_q    <= 1'b0;
			o_wbsec_q <= '0;
			o_last_q  <= 1'b1;
		end else begin
			o_last_q <= o_last_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = o_hit_q;
	assign slot             = o_slot_q;
	assign fill_from_disk   = o_fill_q;
	assign write_to_disk    = o_wtd_q;
	assign disk_sector      = o_dsec_q;
	assign writeback        = o_wb_q;
	assign writeback_sector = o_wbsec_q;
	assign last             = o_last_q;

endmodule

// ===== hdl/lru_sector_cache_directory.sv =====
// ----------------------------------------------------------------------------
// lru_sector_cache_directory
// Tag directory of a fully associative sector cache with LRU replacement and
// write-back or write-through mode.
//
//   channel  handshake                   payload
//   request  in_valid / in_stall         operation, sector
//   result   out_valid / out_stall       hit, slot, fill_from_disk,
//                                        write_to_disk, disk_sector,
//                                        writeback, writeback_sector, last
//   config   cfg_wr_en                   cfg_index, cfg_data
//
// A read or write walks the recency list one position per cycle through the
// tag memory read port and one comparator. A flush visits the list positions
// oldest first, reading each tag, until the dirty entries are all sent, one
// result each; when no entry is dirty, a flush sends a single result.
// Reset clears the dirty bits and fill count; no clearing pass is needed.
// A result waits in the output register while out_stall is high; the next
// request is taken meanwhile, and its result waits for the register.
// ----------------------------------------------------------------------------
module lru_sector_cache_directory import lscd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  op_t                   operation,
	input  sec_t                  sector,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  hit,
	output logic [SLOT_OUT_W-1:0] slot,
	output logic                  fill_from_disk,
	output logic                  write_to_disk,
	output sec_t                  disk_sector,
	output logic                  writeback,
	output sec_t                  writeback_sector,
	output logic                  last,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  cfg_idx_t              cfg_index,
	input  sec_t                  cfg_data
);

	logic       wt_mode_q;
	sec_t       part_base_q;
	slot_t      rd_pos;
	slot_t      rd_slot;
	slot_t      victim_slot;
	lru_shift_t lru_shift;
	logic       tag_rd_en;
	sec_t       tag_rd_data;
	tag_wr_t    tag_wr;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_mode_q   <= 1'b0;
			part_base_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WT_MODE:   wt_mode_q   <= cfg_data[0];
				CFG_PART_BASE: part_base_q <= cfg_data;
				default:       wt_mode_q   <= wt_mode_q;
			endcase
		end
	end

	// sequencer
	lscd_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.sector           (sector),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.slot             (slot),
		.fill_from_disk   (fill_from_disk),
		.write_to_disk    (write_to_disk),
		.disk_sector      (disk_sector),
		.writeback        (writeback),
		.writeback_sector (writeback_sector),
		.last             (last),
		.wt_mode          (wt_mode_q),
		.part_base        (part_base_q),
		.rd_pos           (rd_pos),
		.rd_slot          (rd_slot),
		.victim_slot      (victim_slot),
		.lru_shift        (lru_shift),
		.tag_rd_en        (tag_rd_en),
		.tag_rd_data      (tag_rd_data),
		.tag_wr           (tag_wr)
	);

	// recency list
	lscd_recency u_recency (
		.clk         (clk),
		.rd_pos      (rd_pos),
		.rd_slot     (rd_slot),
		.victim_slot (victim_slot),
		.shift       (lru_shift)
	);

	// tag memory
	lscd_tag_ram u_tag_ram (
		.clk     (clk),
		.rd_en   (tag_rd_en),
		.rd_addr (rd_slot),
		.rd_data (tag_rd_data),
		.wr      (tag_wr)
	);

endmodule
